// ===== src/irpwc_pkg.sv =====
package irpwc_pkg;

  // Number of capture slots. The slot index saturates at SLOT_COUNT - 1.
  localparam int unsigned SLOT_COUNT = 128;
  localparam int unsigned SlotIdxW   = $clog2(SLOT_COUNT);

  // Widths of the result fields.
  localparam int unsigned SlotW = 7;
  localparam int unsigned TickW = 32;

  // Timeout after reset and the duration carried by an end-of-frame result.
  localparam logic [TickW-1:0] TimeoutReset = TickW'(10000);
  localparam logic [TickW-1:0] EndMarker    = TickW'(500);

  // Input command codes.
  localparam logic CmdSample = 1'b0;
  localparam logic CmdRearm  = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOW  = 2'd0,
    KIND_HIGH = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

endpackage

// ===== src/irpwc_in_if.sv =====
interface irpwc_in_if;
  logic valid;
  logic ready;
  logic command;
  logic pin_level;
  logic tx_active;

  modport source (output valid, output command, output pin_level, output tx_active,
                  input ready);
  modport sink (input valid, input command, input pin_level, input tx_active,
                output ready);
endinterface

// ===== src/irpwc_out_if.sv =====
interface irpwc_out_if;
  logic                          valid;
  logic                          ready;
  irpwc_pkg::kind_e              kind;
  logic [irpwc_pkg::TickW-1:0]   duration;
  logic [irpwc_pkg::SlotW-1:0]   slot;

  modport source (output valid, output kind, output duration, output slot,
                  input ready);
  modport sink (input valid, input kind, input duration, input slot,
                output ready);
endinterface

// ===== src/ir_pulse_width_capture_unit.sv =====
// Infrared pulse-width capture. Each input transaction carries one sampled
// receiver pin level (one timer tick), or a rearm command. While capture is
// armed and the transmitter is idle, every sample advances a free-running
// 32-bit tick count that timestamps pin edges. After the first falling edge,
// each rising edge reports the low time just ended and each later falling
// edge reports the high time just ended, both tagged with a slot number that
// advances per result and saturates at the last slot. When the pin stays
// high for more than timeout_q ticks after a rise, an end-of-frame result
// with duration 500 is reported and capture disarms until a rearm command.
// Durations are modulo 2^32. The block takes one transaction per cycle: all
// per-sample work is an increment, two subtracts and one compare feeding the
// result register, and a new transaction is accepted whenever the result
// register is empty or is being drained in the same cycle, so a stalled result
// only holds off the input while it waits. Results are registered.
// The timeout register may be written only while the block is idle.
module ir_pulse_width_capture_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irpwc_pkg::TickW-1:0] cfg_wdata_i,
  irpwc_in_if.sink                    in_i,
  irpwc_out_if.source                 out_o
);

  localparam int unsigned TickW    = irpwc_pkg::TickW;
  localparam int unsigned SlotIdxW = irpwc_pkg::SlotIdxW;
  localparam logic [SlotIdxW-1:0] SlotLast = SlotIdxW'(irpwc_pkg::SLOT_COUNT - 1);

  // Configuration.
  logic [TickW-1:0] timeout_q;

  // Capture state.
  logic                armed_q,        armed_d;
  logic [TickW-1:0]    tick_q,         tick_d;
  logic                last_level_q,   last_level_d;
  logic [TickW-1:0]    fall_stamp_q,   fall_stamp_d;
  logic [TickW-1:0]    rise_stamp_q,   rise_stamp_d;
  logic                frame_q,        frame_d;
  logic                await_fall_q,   await_fall_d;
  logic [SlotIdxW-1:0] slot_idx_q,     slot_idx_d;

  // Result register.
  logic                           out_valid_q;
  irpwc_pkg::kind_e               out_kind_q;
  logic [TickW-1:0]               out_dur_q;
  logic [irpwc_pkg::SlotW-1:0]    out_slot_q;

  logic             in_accept;
  logic             emit;
  irpwc_pkg::kind_e emit_kind;
  logic [TickW-1:0] emit_dur;
  logic [TickW-1:0] tick_inc;
  logic [TickW-1:0] since_rise;
  logic             fall_edge;
  logic             rise_edge;

  // The input side only waits while a finished result is stalled.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign tick_inc   = tick_q + TickW'(1);
  assign fall_edge  = last_level_q && !in_i.pin_level;
  assign rise_edge  = !last_level_q && in_i.pin_level;
  // Elapsed ticks since the last rise, taken modulo 2^32 so wrap is harmless.
  assign since_rise = tick_inc - rise_stamp_q;

  always_comb begin
    armed_d      = armed_q;
    tick_d       = tick_q;
    last_level_d = last_level_q;
    fall_stamp_d = fall_stamp_q;
    rise_stamp_d = rise_stamp_q;
    frame_d      = frame_q;
    await_fall_d = await_fall_q;
    slot_idx_d   = slot_idx_q;
    emit         = 1'b0;
    emit_kind    = irpwc_pkg::KIND_LOW;
    emit_dur     = '0;

    if (in_i.command == irpwc_pkg::CmdRearm) begin
      // Rearm restores the reset state; the timeout register is kept.
      armed_d      = 1'b1;
      tick_d       = '0;
      last_level_d = 1'b1;
      fall_stamp_d = '0;
      rise_stamp_d = '0;
      frame_d      = 1'b0;
      await_fall_d = 1'b0;
      slot_idx_d   = '0;
    end else if (armed_q && !in_i.tx_active) begin
      tick_d       = tick_inc;
      last_level_d = in_i.pin_level;
      if (fall_edge) begin
        // The first fall of a frame only opens it; later falls close a high time.
        fall_stamp_d = tick_inc;
        emit         = frame_q;
        emit_kind    = irpwc_pkg::KIND_HIGH;
        emit_dur     = since_rise;
        frame_d      = 1'b1;
        await_fall_d = 1'b0;
      end else if (rise_edge) begin
        rise_stamp_d = tick_inc;
        emit         = 1'b1;
        emit_kind    = irpwc_pkg::KIND_LOW;
        emit_dur     = tick_inc - fall_stamp_q;
        await_fall_d = 1'b1;
      end else if (await_fall_q && (since_rise > timeout_q)) begin
        // The line has stayed high too long: the frame is over.
        armed_d      = 1'b0;
        emit         = 1'b1;
        emit_kind    = irpwc_pkg::KIND_END;
        emit_dur     = irpwc_pkg::EndMarker;
        frame_d      = 1'b0;
        await_fall_d = 1'b0;
      end
      if (emit && (slot_idx_q < SlotLast)) begin
        slot_idx_d = slot_idx_q + SlotIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= irpwc_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b1;
      tick_q       <= '0;
      last_level_q <= 1'b1;
      fall_stamp_q <= '0;
      rise_stamp_q <= '0;
      frame_q      <= 1'b0;
      await_fall_q <= 1'b0;
      slot_idx_q   <= '0;
    end else if (in_accept) begin
      armed_q      <= armed_d;
      tick_q       <= tick_d;
      last_level_q <= last_level_d;
      fall_stamp_q <= fall_stamp_d;
      rise_stamp_q <= rise_stamp_d;
      frame_q      <= frame_d;
      await_fall_q <= await_fall_d;
      slot_idx_q   <= slot_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The slot reported is the one in use before this result advances it.
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_kind_q <= emit_kind;
      out_dur_q  <= emit_dur;
      out_slot_q <= irpwc_pkg::SlotW'(slot_idx_q);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.duration = out_dur_q;
  assign out_o.slot     = out_slot_q;

endmodule

// ===== src/irpwc_checker.sv =====
module irpwc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_command_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  out_kind_i,
  input logic [irpwc_pkg::TickW-1:0] out_duration_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result keeps its kind and duration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
                                     && $stable(out_duration_i))
    else $error("stalled result changed");

  // With no result pending, the block must take input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input held off with empty result register");

  // A rearm transaction produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_command_i == irpwc_pkg::CmdRearm) && (!out_valid_i || out_ready_i)
      |=> !out_valid_i)
    else $error("rearm produced a result");

  // End-of-frame results always carry the marker duration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == irpwc_pkg::KIND_END)
      |-> out_duration_i == irpwc_pkg::EndMarker)
    else $error("end of frame without marker");

  // The unused kind code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_kind_i <= 2'(irpwc_pkg::KIND_END))
    else $error("invalid result kind");

endmodule

bind ir_pulse_width_capture_unit irpwc_checker u_irpwc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_duration_i (out_o.duration)
);

// ===== test/ir_pulse_width_capture_unit_tb.sv =====
module ir_pulse_width_capture_unit_tb;

  localparam int unsigned TickW = irpwc_pkg::TickW;
  localparam int unsigned SlotW = irpwc_pkg::SlotW;

  // Run length guard. The slowest correct run is far below this: roughly
  // 1.2k transactions, each at worst behind one source idle burst and one
  // sink stall.
  localparam int unsigned CycleLimit = 2_000_000;

  // One input transaction as the driver holds it.
  typedef struct packed {
    logic command;
    logic pin_level;
    logic tx_active;
  } sample_t;

  // One result transaction as the monitor expects it.
  typedef struct packed {
    irpwc_pkg::kind_e kind;
    logic [TickW-1:0] duration;
    logic [SlotW-1:0] slot;
  } pulse_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [TickW-1:0] cfg_wdata;

  irpwc_in_if  in_if ();
  irpwc_out_if out_if ();

  ir_pulse_width_capture_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Samples waiting to be driven, and pulse results predicted but not yet seen.
  sample_t sample_q[$];
  pulse_t  pulse_q[$];

  int unsigned queued_samples;
  int unsigned fail_count;
  int unsigned cycle_count;

  // When set, neither side inserts idle cycles.
  bit calm;

  // Idle counters for the source and sink bursts.
  int unsigned src_gap;
  int unsigned sink_gap;

  // Predictor copy of the capture state and of the timeout register.
  logic [TickW-1:0] timeout_cfg;
  bit               m_armed;
  logic [TickW-1:0] m_ticks;
  logic             m_last_level;
  logic [TickW-1:0] m_fall_at;
  logic [TickW-1:0] m_rise_at;
  bit               m_in_frame;
  bit               m_wait_fall;
  int unsigned      m_slot;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Free-running cycle count. If the run has not finished by the limit,
  // something is stuck, so the run ends as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Capture state as it stands after reset or after a rearm command.
  function automatic void clear_capture();
    m_armed      = 1'b1;
    m_ticks      = '0;
    m_last_level = 1'b1;
    m_fall_at    = '0;
    m_rise_at    = '0;
    m_in_frame   = 1'b0;
    m_wait_fall  = 1'b0;
    m_slot       = 0;
  endfunction

  // Advance the capture state by one accepted sample and queue the pulse
  // result it produces, if any.
  task automatic capture_sample(input sample_t s);
    logic             prev;
    logic [TickW-1:0] since_rise;
    bit               hit;
    pulse_t           r;
    hit = 1'b0;
    r   = '0;
    if (s.command == irpwc_pkg::CmdRearm) begin
      clear_capture();
      return;
    end
    // A disarmed block or a busy transmitter leaves everything untouched.
    if (!m_armed || s.tx_active) begin
      return;
    end
    m_ticks      = m_ticks + 1'b1;
    prev         = m_last_level;
    m_last_level = s.pin_level;
    if (prev && !s.pin_level) begin
      // Falling edge: it closes a high period, unless it opens the frame.
      m_fall_at = m_ticks;
      if (m_in_frame) begin
        r.kind     = irpwc_pkg::KIND_HIGH;
        r.duration = m_ticks - m_rise_at;
        hit        = 1'b1;
      end
      m_in_frame  = 1'b1;
      m_wait_fall = 1'b0;
    end else if (!prev && s.pin_level) begin
      // Rising edge: it closes a low period.
      m_rise_at   = m_ticks;
      r.kind      = irpwc_pkg::KIND_LOW;
      r.duration  = m_ticks - m_fall_at;
      hit         = 1'b1;
      m_wait_fall = 1'b1;
    end
    // The elapsed time since the rise is a modular difference, so a counter
    // wrap does not fire the timeout early.
    since_rise = m_ticks - m_rise_at;
    if (!hit && m_wait_fall && since_rise > timeout_cfg) begin
      m_armed     = 1'b0;
      r.kind      = irpwc_pkg::KIND_END;
      r.duration  = irpwc_pkg::EndMarker;
      hit         = 1'b1;
      m_in_frame  = 1'b0;
      m_wait_fall = 1'b0;
    end
    if (hit) begin
      // The slot number saturates at the last slot instead of wrapping.
      r.slot = SlotW'(m_slot);
      if (m_slot < irpwc_pkg::SLOT_COUNT - 1) begin
        m_slot++;
      end
      pulse_q.push_back(r);
    end
  endtask

  // Driver. A sample is accepted at an edge where valid and ready were both
  // high; the predictor runs on it right there. A new sample is loaded
  // whenever the output slot is empty or was just accepted, unless an idle
  // burst is running.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.command   <= irpwc_pkg::CmdSample;
      in_if.pin_level <= 1'b1;
      in_if.tx_active <= 1'b0;
      src_gap         <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        capture_sample('{command: in_if.command, pin_level: in_if.pin_level,
                         tx_active: in_if.tx_active});
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap     <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          if (!calm && $urandom_range(0, 11) == 0) begin
            // Start an idle burst that begins with this cycle.
            src_gap     <= $urandom_range(0, 17);
            in_if.valid <= 1'b0;
          end else begin
            in_if.valid     <= 1'b1;
            in_if.command   <= sample_q[0].command;
            in_if.pin_level <= sample_q[0].pin_level;
            in_if.tx_active <= sample_q[0].tx_active;
            void'(sample_q.pop_front());
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result is checked against the oldest prediction.
  // Ready drops in random bursts to exercise the back-pressure path.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pulse_q.size() == 0) begin
          $error("unexpected result: kind %0d, duration %0d, slot %0d",
                 out_if.kind, out_if.duration, out_if.slot);
          fail_count++;
        end else begin
          if (out_if.kind !== pulse_q[0].kind) begin
            $error("kind mismatch: expected %0d, actual %0d",
                   pulse_q[0].kind, out_if.kind);
            fail_count++;
          end
          if (out_if.duration !== pulse_q[0].duration) begin
            $error("duration mismatch: expected %0d, actual %0d",
                   pulse_q[0].duration, out_if.duration);
            fail_count++;
          end
          if (out_if.slot !== pulse_q[0].slot) begin
            $error("slot mismatch: expected %0d, actual %0d",
                   pulse_q[0].slot, out_if.slot);
            fail_count++;
          end
          void'(pulse_q.pop_front());
        end
      end
      if (sink_gap > 0) begin
        sink_gap     <= sink_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_gap     <= $urandom_range(0, 17);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_sample(input logic cmd, input logic pin, input logic tx);
    sample_q.push_back('{command: cmd, pin_level: pin, tx_active: tx});
    queued_samples++;
  endtask

  // A run of samples at one pin level. Now and then a busy-transmitter
  // sample with a random level is slipped in; it must not count as a tick.
  task automatic add_run(input logic level, input int unsigned len);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) begin
        add_sample(irpwc_pkg::CmdSample, 1'($urandom_range(0, 1)), 1'b1);
      end
      add_sample(irpwc_pkg::CmdSample, level, 1'b0);
    end
  endtask

  // One frame: idle high, a train of low and high pulses, then a high
  // stretch that outlasts small timeouts, then a rearm. A few high pulses
  // run past a short timeout on purpose, which cuts the frame short.
  task automatic add_frame(input longint unsigned tmo, input int unsigned pulses,
                           input int unsigned max_len);
    int unsigned hi_cap;
    int unsigned hi_len;
    hi_cap = (tmo + 1 < max_len) ? int'(tmo + 1) : max_len;
    add_run(1'b1, $urandom_range(1, 3));
    repeat (pulses) begin
      add_run(1'b0, $urandom_range(1, max_len));
      if ($urandom_range(0, 9) == 0) begin
        hi_len = hi_cap + $urandom_range(1, 3);
      end else begin
        hi_len = $urandom_range(1, hi_cap);
      end
      add_run(1'b1, hi_len);
    end
    if (tmo < 40) begin
      add_run(1'b1, int'(tmo) + $urandom_range(1, 3));
    end
    add_sample(irpwc_pkg::CmdRearm, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Wait until every sample is accepted and every result has arrived, then
  // let the clock run on so that a sample that yields no result is done too.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (sample_q.size() != 0 || in_if.valid || pulse_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TickW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    timeout_cfg = value;
  endtask

  // One phase of random traffic under one timeout setting. Most of it is
  // well-formed frames; the rest is noise with random commands and levels.
  task automatic run_phase(input logic [TickW-1:0] tmo, input bit quiet,
                           input int unsigned budget, input bit fill_slots);
    int unsigned start;
    wait_idle();
    write_timeout(tmo);
    calm  = quiet;
    start = queued_samples;
    add_sample(irpwc_pkg::CmdRearm, 1'b1, 1'b0);
    // A long frame of short pulses drives the slot number into saturation.
    if (fill_slots) begin
      add_frame(64'(tmo), 80, 2);
    end
    while (queued_samples - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          add_sample(1'($urandom_range(0, 15) == 0), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
      end else begin
        add_frame(64'(tmo), $urandom_range(1, 10), (tmo > 40) ? 30 : 12);
      end
    end
  endtask

  initial begin
    // Every input of the block is known from time zero.
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.command   = irpwc_pkg::CmdSample;
    in_if.pin_level = 1'b1;
    in_if.tx_active = 1'b0;
    out_if.ready    = 1'b0;
    calm            = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    queued_samples  = 0;
    timeout_cfg     = irpwc_pkg::TimeoutReset;
    clear_capture();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset timeout. A rearm first, then the first
    // fall which opens the frame without a result, one-tick pulses, a busy
    // transmitter sample in the middle of a pulse, and a rearm in mid-frame
    // with the transmitter busy bit set.
    add_sample(irpwc_pkg::CmdRearm, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b1);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b1);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdRearm, 1'b0, 1'b1);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    // A long high stretch stays well inside the reset timeout.
    repeat (40) add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdRearm, 1'b1, 1'b0);

    // With a short timeout, hold the pin high past it so that the frame ends.
    wait_idle();
    write_timeout(TickW'(3));
    add_sample(irpwc_pkg::CmdRearm, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    repeat (5) add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    // While disarmed, edges must be ignored until the next rearm.
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b1, 1'b0);
    add_sample(irpwc_pkg::CmdSample, 1'b0, 1'b0);
    add_sample(irpwc_pkg::CmdRearm, 1'b1, 1'b0);

    // Random phases over several timeouts, the extremes among them. The
    // largest timeout never expires, so that phase also fills every slot.
    run_phase(TickW'(1), 1'b0, 80, 1'b0);
    run_phase({TickW{1'b1}}, 1'b0, 80, 1'b1);
    run_phase(TickW'(2), 1'b0, 80, 1'b0);
    run_phase(TickW'(5), 1'b0, 80, 1'b0);
    run_phase(TickW'($urandom_range(3, 20)), 1'b0, 80, 1'b0);
    run_phase(TickW'($urandom), 1'b0, 80, 1'b0);
    run_phase(TickW'($urandom_range(1, 40)), 1'b0, 80, 1'b0);
    // The last phase runs without idling on either side.
    run_phase(TickW'(4), 1'b1, 80, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
